// ===== hw/rtl/c8_pkg.sv =====
// ----------------------------------------------------------------------------
// c8_pkg - shared types and constants
// Request codes, opcode groups, fixed geometry and the transfer structs used
// between the CHIP-8 core's handshake stage and its execution engine.
// ----------------------------------------------------------------------------
package c8_pkg;

	// fixed geometry
	localparam int RAM_BYTES     = 4096;
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;
	localparam int ADDR_W        = 12;
	localparam int ROW_W         = 5;
	localparam int XPOS_W        = 6;

	// parameter defaults
	localparam int STACK_DEPTH_DEF = 16;
	localparam int ENTRY_POINT_DEF = 512;

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_EXEC  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_ROW   = 2'd3;

	// opcode groups
	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JMP  = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEQI = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4;
	localparam logic [3:0] OP_SEQR = 4'h5;
	localparam logic [3:0] OP_LDI  = 4'h6;
	localparam logic [3:0] OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_SETI = 4'hA;
	localparam logic [3:0] OP_JMPV = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRAW = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// ALU sub-codes (low nibble of 8XYN)
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// key sub-codes
	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;

	// misc sub-codes
	localparam logic [7:0] MISC_GDT  = 8'h07;
	localparam logic [7:0] MISC_WKEY = 8'h0A;
	localparam logic [7:0] MISC_SDT  = 8'h15;
	localparam logic [7:0] MISC_SST  = 8'h18;
	localparam logic [7:0] MISC_ADDI = 8'h1E;
	localparam logic [7:0] MISC_FONT = 8'h29;
	localparam logic [7:0] MISC_BCD  = 8'h33;
	localparam logic [7:0] MISC_DUMP = 8'h55;
	localparam logic [7:0] MISC_LOAD = 8'h65;

	localparam logic [3:0] FLAG_REG = 4'hF;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ADDR_W-1:0] address;
		logic [7:0]        write_data;
		logic [15:0]       key_state;
		logic [7:0]        random_byte;
	} req_t;

	typedef struct packed {
		logic [63:0]       read_value;
		logic [ADDR_W-1:0] program_counter;
		logic [15:0]       fetched_opcode;
		logic              waiting_for_key;
		logic              screen_changed;
		logic              bad_opcode;
		logic              sound_on;
	} res_t;

endpackage

// ===== hw/rtl/c8_req_if.sv =====
// ----------------------------------------------------------------------------
// c8_req_if - request channel
// Valid/ready channel carrying one core request per transfer.
// ----------------------------------------------------------------------------
interface c8_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [11:0] address;
	logic [7:0]  write_data;
	logic [15:0] key_state;
	logic [7:0]  random_byte;

	modport source (output valid, output req_type, output address, output write_data,
		output key_state, output random_byte, input ready);
	modport sink (input valid, input req_type, input address, input write_data,
		input key_state, input random_byte, output ready);
endinterface

// ===== hw/rtl/c8_rsp_if.sv =====
// ----------------------------------------------------------------------------
// c8_rsp_if - response channel
// Valid/ready channel carrying one core response per transfer.
// ----------------------------------------------------------------------------
interface c8_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] read_value;
	logic [11:0] program_counter;
	logic [15:0] fetched_opcode;
	logic        waiting_for_key;
	logic        screen_changed;
	logic        bad_opcode;
	logic        sound_on;

	modport source (output valid, output read_value, output program_counter,
		output fetched_opcode, output waiting_for_key, output screen_changed,
		output bad_opcode, output sound_on, input ready);
	modport sink (input valid, input read_value, input program_counter,
		input fetched_opcode, input waiting_for_key, input screen_changed,
		input bad_opcode, input sound_on, output ready);
endinterface

// ===== hw/rtl/c8_exec.sv =====
// ----------------------------------------------------------------------------
// c8_exec - execution engine
// Sequencer around the RAM, frame buffer, register file and return stack
// memories: fetch, decode, execute and multi-cycle draw, BCD, dump and load.
// ----------------------------------------------------------------------------
module c8_exec #(
	parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF,
	parameter int ENTRY_POINT = c8_pkg::ENTRY_POINT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  c8_pkg::req_t req,
	output logic         idle,
	input  logic         res_ready,
	output logic         res_valid,
	output c8_pkg::res_t res
);

	localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [SP_W-1:0] SP_MAX = SP_W'(STACK_DEPTH - 1);
	localparam int AW = c8_pkg::ADDR_W;
	localparam int RW = c8_pkg::ROW_W;
	localparam int XW = c8_pkg::XPOS_W;

	typedef enum logic [3:0] {
		S_IDLE, S_RDRAM, S_RDFB, S_F1, S_F2, S_EX, S_RET, S_WRF,
		S_DRD, S_DWR, S_BCD, S_DUMP_RD, S_DUMP_WR, S_LOAD_RD, S_LOAD_WR, S_DONE
	} state_t;

	state_t state_q;

	// memories
	logic [7:0]  ram_mem [c8_pkg::RAM_BYTES];
	logic [63:0] fb_mem  [c8_pkg::SCREEN_HEIGHT];
	logic [7:0]  rf_mem  [16];
	logic [AW-1:0] stk_mem [STACK_DEPTH];

	logic [c8_pkg::SCREEN_HEIGHT-1:0] fb_vld_q;
	logic [15:0] rf_vld_q;

	logic          ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [7:0]    ram_wd, ram_rd;
	logic          fb_we, fb_clr, fb_rvld_q;
	logic [RW-1:0] fb_wa, fb_ra;
	logic [63:0]   fb_wd, fb_rd, fb_eff;
	logic          rf_we, rf_va_q, rf_vb_q;
	logic [3:0]    rf_wa, ra_a, ra_b;
	logic [7:0]    rf_wd, rf_rda, rf_rdb, vx, vy;
	logic            stk_we;
	logic [SP_W-1:0] stk_wa, stk_ra;
	logic [AW-1:0]   stk_wd, stk_rd;

	// architectural and work registers
	logic [AW-1:0]   pc_q, i_q;
	logic [SP_W-1:0] sp_q;
	logic [7:0]      dt_q, st_q;
	logic [15:0]     keys_q;
	logic [7:0]      rnd_q, hi_q, flag_q, d1_q, d0_q;
	logic [15:0]     op_q;
	logic [63:0]     rv_q;
	logic            wait_q, scr_q, bad_q, hit_q;
	logic [4:0]      cnt_q;
	logic [XW-1:0]   x0_q;
	logic [RW-1:0]   y0_q;

	// opcode fields
	logic [3:0]    grp, fx, fy, fn;
	logic [7:0]    nn;
	logic [AW-1:0] nnn;
	assign grp = op_q[15:12];
	assign fx  = op_q[11:8];
	assign fy  = op_q[7:4];
	assign fn  = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];

	assign vx     = rf_va_q ? rf_rda : 8'h00;
	assign vy     = rf_vb_q ? rf_rdb : 8'h00;
	assign fb_eff = fb_rvld_q ? fb_rd : 64'h0;

	logic [SP_W-1:0] sp_inc, sp_dec;
	assign sp_inc = (sp_q == SP_MAX) ? '0 : sp_q + SP_W'(1);
	assign sp_dec = (sp_q == '0) ? SP_MAX : sp_q - SP_W'(1);

	// draw row addressing and sprite mask
	logic [RW:0]   row6, row6_nxt;
	logic [4:0]    cnt_nxt;
	logic [63:0]   draw_mask;
	logic          draw_cont, hit_nxt;
	logic [AW-1:0] i_off;
	assign row6      = {1'b0, y0_q} + {1'b0, cnt_q};
	assign row6_nxt  = row6 + 6'd1;
	assign cnt_nxt   = cnt_q + 5'd1;
	assign draw_mask = {ram_rd, 56'h0} >> x0_q;
	assign draw_cont = (cnt_nxt < {1'b0, fn}) && (row6_nxt < 6'(c8_pkg::SCREEN_HEIGHT));
	assign hit_nxt   = hit_q | (|(fb_eff & draw_mask));
	assign i_off     = i_q + {{(AW-5){1'b0}}, cnt_q};

	// 8XYN arithmetic
	logic [8:0] alu_res;
	logic       alu_flag, alu_has_flag, alu_bad;
	always_comb begin
		alu_res      = {1'b0, vx};
		alu_flag     = 1'b0;
		alu_has_flag = 1'b1;
		alu_bad      = 1'b0;
		unique case (fn)
			c8_pkg::ALU_MOV: begin alu_res = {1'b0, vy}; alu_has_flag = 1'b0; end
			c8_pkg::ALU_OR:  begin alu_res = {1'b0, vx | vy}; alu_has_flag = 1'b0; end
			c8_pkg::ALU_AND: begin alu_res = {1'b0, vx & vy}; alu_has_flag = 1'b0; end
			c8_pkg::ALU_XOR: begin alu_res = {1'b0, vx ^ vy}; alu_has_flag = 1'b0; end
			c8_pkg::ALU_ADD: begin
				alu_res  = {1'b0, vx} + {1'b0, vy};
				alu_flag = alu_res[8];
			end
			c8_pkg::ALU_SUB: begin
				alu_res  = {1'b0, vx} - {1'b0, vy};
				alu_flag = (vy <= vx);
			end
			c8_pkg::ALU_SHR: begin alu_res = {2'b0, vx[7:1]}; alu_flag = vx[0]; end
			c8_pkg::ALU_SBN: begin
				alu_res  = {1'b0, vy} - {1'b0, vx};
				alu_flag = (vx <= vy);
			end
			c8_pkg::ALU_SHL: begin alu_res = {vx, 1'b0}; alu_flag = vx[7]; end
			default: begin alu_bad = 1'b1; alu_has_flag = 1'b0; end
		endcase
	end

	// lowest pressed key
	logic       key_found;
	logic [3:0] key_idx;
	always_comb begin
		key_found = 1'b0;
		key_idx   = 4'h0;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k]) begin
				key_found = 1'b1;
				key_idx   = 4'(k);
			end
		end
	end

	// BCD digits of VX: reciprocal multiply for the tens digit
	logic [1:0]  bcd_h;
	logic [6:0]  bcd_r;
	logic [14:0] bcd_tm;
	logic [3:0]  bcd_t, bcd_o;
	always_comb begin
		bcd_h  = (vx >= 8'd200) ? 2'd2 : (vx >= 8'd100) ? 2'd1 : 2'd0;
		bcd_r  = 7'(vx - 8'(bcd_h) * 8'd100);
		bcd_tm = 15'(bcd_r) * 15'd205;
		bcd_t  = bcd_tm[14:11];
		bcd_o  = 4'(bcd_r - 7'(bcd_t) * 7'd10);
	end

	logic key_hit;
	assign key_hit = keys_q[vx[3:0]];

	// memory port control
	always_comb begin
		ram_we = 1'b0;
		ram_wa = i_off;
		ram_wd = vx;
		ram_ra = pc_q;
		fb_we  = 1'b0;
		fb_clr = 1'b0;
		fb_wa  = row6[RW-1:0];
		fb_wd  = fb_eff ^ draw_mask;
		fb_ra  = row6[RW-1:0];
		rf_we  = 1'b0;
		rf_wa  = fx;
		rf_wd  = alu_res[7:0];
		ra_a   = cnt_q[3:0];
		ra_b   = fy;
		stk_we = 1'b0;
		stk_wa = sp_q;
		stk_wd = pc_q;
		stk_ra = sp_dec;
		unique case (state_q)
			S_IDLE: begin
				ram_ra = (req.req_type == c8_pkg::REQ_EXEC) ? pc_q : req.address;
				fb_ra  = req.address[RW-1:0];
				ram_we = start && (req.req_type == c8_pkg::REQ_WRITE);
				ram_wa = req.address;
				ram_wd = req.write_data;
			end
			S_F1: ram_ra = pc_q + 12'd1;
			S_F2: begin
				ra_a = (hi_q[7:4] == c8_pkg::OP_JMPV) ? 4'h0 : hi_q[3:0];
				ra_b = ram_rd[7:4];
			end
			S_EX: begin
				unique case (grp)
					c8_pkg::OP_SYS:  fb_clr = (op_q == c8_pkg::OP_CLS);
					c8_pkg::OP_CALL: stk_we = 1'b1;
					c8_pkg::OP_LDI:  begin rf_we = 1'b1; rf_wd = nn; end
					c8_pkg::OP_ADDI: begin rf_we = 1'b1; rf_wd = vx + nn; end
					c8_pkg::OP_RND:  begin rf_we = 1'b1; rf_wd = rnd_q & nn; end
					c8_pkg::OP_ALU:  rf_we = !alu_bad;
					c8_pkg::OP_MISC: begin
						unique case (nn)
							c8_pkg::MISC_GDT: begin rf_we = 1'b1; rf_wd = dt_q; end
							c8_pkg::MISC_WKEY: begin
								rf_we = key_found;
								rf_wd = {4'h0, key_idx};
							end
							c8_pkg::MISC_BCD: begin
								ram_we = 1'b1;
								ram_wa = i_q;
								ram_wd = {6'h0, bcd_h};
							end
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			S_WRF: begin rf_we = 1'b1; rf_wa = c8_pkg::FLAG_REG; rf_wd = flag_q; end
			S_DRD: ram_ra = i_off;
			S_DWR: fb_we = 1'b1;
			S_BCD: begin
				ram_we = 1'b1;
				ram_wd = (cnt_q == 5'd1) ? d1_q : d0_q;
			end
			S_DUMP_WR: ram_we = 1'b1;
			S_LOAD_RD: ram_ra = i_off;
			S_LOAD_WR: begin rf_we = 1'b1; rf_wa = cnt_q[3:0]; rf_wd = ram_rd; end
			default: ;
		endcase
	end

	// memory arrays
	always_ff @(posedge clk) begin
		if (ram_we) ram_mem[ram_wa] <= ram_wd;
		ram_rd <= ram_mem[ram_ra];
		if (fb_we) fb_mem[fb_wa] <= fb_wd;
		fb_rd <= fb_mem[fb_ra];
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		rf_rda <= rf_mem[ra_a];
		rf_rdb <= rf_mem[ra_b];
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_rd <= stk_mem[stk_ra];
	end

	// valid bits stand in for the zero reset of frame buffer and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_vld_q  <= '0;
			rf_vld_q  <= '0;
			fb_rvld_q <= 1'b0;
			rf_va_q   <= 1'b0;
			rf_vb_q   <= 1'b0;
		end else begin
			fb_rvld_q <= fb_vld_q[fb_ra];
			rf_va_q   <= rf_vld_q[ra_a];
			rf_vb_q   <= rf_vld_q[ra_b];
			if (fb_clr) fb_vld_q <= '0;
			else if (fb_we) fb_vld_q[fb_wa] <= 1'b1;
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= AW'(ENTRY_POINT);
			i_q     <= '0;
			sp_q    <= '0;
			dt_q    <= '0;
			st_q    <= '0;
			keys_q  <= '0;
			rnd_q   <= '0;
			hi_q    <= '0;
			op_q    <= '0;
			rv_q    <= '0;
			wait_q  <= 1'b0;
			scr_q   <= 1'b0;
			bad_q   <= 1'b0;
			hit_q   <= 1'b0;
			flag_q  <= '0;
			d1_q    <= '0;
			d0_q    <= '0;
			cnt_q   <= '0;
			x0_q    <= '0;
			y0_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						keys_q <= req.key_state;
						rnd_q  <= req.random_byte;
						op_q   <= '0;
						rv_q   <= '0;
						wait_q <= 1'b0;
						scr_q  <= 1'b0;
						bad_q  <= 1'b0;
						unique case (req.req_type)
							c8_pkg::REQ_WRITE: state_q <= S_DONE;
							c8_pkg::REQ_EXEC:  state_q <= S_F1;
							c8_pkg::REQ_READ:  state_q <= S_RDRAM;
							default:           state_q <= S_RDFB;
						endcase
					end
				end
				S_RDRAM: begin rv_q <= {56'h0, ram_rd}; state_q <= S_DONE; end
				S_RDFB:  begin rv_q <= fb_eff; state_q <= S_DONE; end
				S_F1:    begin hi_q <= ram_rd; state_q <= S_F2; end
				S_F2: begin
					op_q    <= {hi_q, ram_rd};
					pc_q    <= pc_q + 12'd2;
					state_q <= S_EX;
				end
				S_EX: begin
					state_q <= S_DONE;
					unique case (grp)
						c8_pkg::OP_SYS: begin
							if (op_q == c8_pkg::OP_CLS) scr_q <= 1'b1;
							else if (op_q == c8_pkg::OP_RET) begin
								sp_q    <= sp_dec;
								state_q <= S_RET;
							end else bad_q <= 1'b1;
						end
						c8_pkg::OP_JMP:  pc_q <= nnn;
						c8_pkg::OP_CALL: begin sp_q <= sp_inc; pc_q <= nnn; end
						c8_pkg::OP_SEQI: if (vx == nn) pc_q <= pc_q + 12'd2;
						c8_pkg::OP_SNEI: if (vx != nn) pc_q <= pc_q + 12'd2;
						c8_pkg::OP_SEQR: if (vx == vy) pc_q <= pc_q + 12'd2;
						c8_pkg::OP_SNER: if (vx != vy) pc_q <= pc_q + 12'd2;
						c8_pkg::OP_ALU: begin
							if (alu_bad) bad_q <= 1'b1;
							else if (alu_has_flag) begin
								flag_q  <= {7'h0, alu_flag};
								state_q <= S_WRF;
							end
						end
						c8_pkg::OP_SETI: i_q  <= nnn;
						c8_pkg::OP_JMPV: pc_q <= nnn + {4'h0, vx};
						c8_pkg::OP_DRAW: begin
							x0_q  <= vx[XW-1:0];
							y0_q  <= vy[RW-1:0];
							cnt_q <= '0;
							hit_q <= 1'b0;
							scr_q <= 1'b1;
							if (fn == 4'h0) begin
								flag_q  <= '0;
								state_q <= S_WRF;
							end else state_q <= S_DRD;
						end
						c8_pkg::OP_KEY: begin
							if (nn == c8_pkg::KEY_DOWN) begin
								if (key_hit) pc_q <= pc_q + 12'd2;
							end else if (nn == c8_pkg::KEY_UP) begin
								if (!key_hit) pc_q <= pc_q + 12'd2;
							end else bad_q <= 1'b1;
						end
						c8_pkg::OP_MISC: begin
							unique case (nn)
								c8_pkg::MISC_GDT: ;
								c8_pkg::MISC_WKEY: begin
									if (!key_found) begin
										pc_q   <= pc_q - 12'd2;
										wait_q <= 1'b1;
									end
								end
								c8_pkg::MISC_SDT:  dt_q <= vx;
								c8_pkg::MISC_SST:  st_q <= vx;
								c8_pkg::MISC_ADDI: i_q  <= i_q + {4'h0, vx};
								c8_pkg::MISC_FONT: i_q  <= 12'(vx) * 12'd5;
								c8_pkg::MISC_BCD: begin
									d1_q    <= {4'h0, bcd_t};
									d0_q    <= {4'h0, bcd_o};
									cnt_q   <= 5'd1;
									state_q <= S_BCD;
								end
								c8_pkg::MISC_DUMP: begin cnt_q <= '0; state_q <= S_DUMP_RD; end
								c8_pkg::MISC_LOAD: begin cnt_q <= '0; state_q <= S_LOAD_RD; end
								default: bad_q <= 1'b1;
							endcase
						end
						default: ;
					endcase
				end
				S_RET: begin pc_q <= stk_rd; state_q <= S_DONE; end
				S_WRF: state_q <= S_DONE;
				S_DRD: state_q <= S_DWR;
				S_DWR: begin
					hit_q <= hit_nxt;
					if (draw_cont) begin
						cnt_q   <= cnt_nxt;
						state_q <= S_DRD;
					end else begin
						flag_q  <= {7'h0, hit_nxt};
						state_q <= S_WRF;
					end
				end
				S_BCD: begin
					if (cnt_q == 5'd2) state_q <= S_DONE;
					else cnt_q <= cnt_nxt;
				end
				S_DUMP_RD: state_q <= S_DUMP_WR;
				S_DUMP_WR: begin
					if (cnt_q[3:0] == fx) state_q <= S_DONE;
					else begin cnt_q <= cnt_nxt; state_q <= S_DUMP_RD; end
				end
				S_LOAD_RD: state_q <= S_LOAD_WR;
				S_LOAD_WR: begin
					if (cnt_q[3:0] == fx) state_q <= S_DONE;
					else begin cnt_q <= cnt_nxt; state_q <= S_LOAD_RD; end
				end
				S_DONE: if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result
	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	always_comb begin
		res.read_value      = rv_q;
		res.program_counter = pc_q;
		res.fetched_opcode  = op_q;
		res.waiting_for_key = wait_q;
		res.screen_changed  = scr_q;
		res.bad_opcode      = bad_q;
		res.sound_on        = (st_q != 8'h00);
	end

endmodule

// ===== hw/rtl/chip8_instruction_core.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_core - CHIP-8 core top level
// Request/response handshake and output register around the execution engine.
// ----------------------------------------------------------------------------
// One request is worked at a time; the next is taken once its response is
// in the output register. A plain instruction fetches its two opcode bytes
// from RAM, reads its registers, executes and then gives its response; a
// flag write-back or a return adds a state of its own, a draw reads and
// writes each sprite row, BCD writes its three digits and a register dump or
// load moves each register from V0 to VX in turn. The program RAM gives one
// byte per cycle from a registered read, so the opcode bytes and each sprite
// or register byte are read in states of their own. Display and registers
// power up cleared through valid bits, so no clearing pass follows reset.
module chip8_instruction_core #(
	parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF,
	parameter int ENTRY_POINT = c8_pkg::ENTRY_POINT_DEF
) (
	input logic     clk,
	input logic     arst_n,
	c8_req_if.sink  req_ch,
	c8_rsp_if.source rsp_ch
);

	c8_pkg::req_t req;
	c8_pkg::res_t res, res_q;
	logic idle, start, res_valid, res_ready, out_valid_q;

	assign req.req_type    = req_ch.req_type;
	assign req.address     = req_ch.address;
	assign req.write_data  = req_ch.write_data;
	assign req.key_state   = req_ch.key_state;
	assign req.random_byte = req_ch.random_byte;

	assign req_ch.ready = idle;
	assign start        = req_ch.valid && idle;
	assign res_ready    = !out_valid_q || rsp_ch.ready;

	c8_exec #(
		.STACK_DEPTH(STACK_DEPTH),
		.ENTRY_POINT(ENTRY_POINT)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.idle     (idle),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res      (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) res_q <= res;
	end

	assign rsp_ch.valid           = out_valid_q;
	assign rsp_ch.read_value      = res_q.read_value;
	assign rsp_ch.program_counter = res_q.program_counter;
	assign rsp_ch.fetched_opcode  = res_q.fetched_opcode;
	assign rsp_ch.waiting_for_key = res_q.waiting_for_key;
	assign rsp_ch.screen_changed  = res_q.screen_changed;
	assign rsp_ch.bad_opcode      = res_q.bad_opcode;
	assign rsp_ch.sound_on        = res_q.sound_on;

endmodule

// ===== hw/rtl/c8_chk.sv =====
// ----------------------------------------------------------------------------
// c8_chk - port-level checks
// Concurrent assertions on the response channel, bound to the core top level.
// ----------------------------------------------------------------------------
module c8_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [11:0] pc,
	input logic [15:0] op,
	input logic        wait_key,
	input logic        scr,
	input logic        bad
);

	// a stalled response stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pc) && $stable(op))
		else $error("stalled response changed");

	// key wait only comes from FX0A, never with other flags
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && wait_key |-> !scr && !bad && op[15:12] == 4'hF && op[7:0] == 8'h0A)
		else $error("key wait on wrong opcode");

	// screen change only from clear or draw
	a_scr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && scr |-> op == 16'h00E0 || op[15:12] == 4'hD)
		else $error("screen change on wrong opcode");

	// bad opcode never from a group that is fully decoded
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bad |-> op[15:12] == 4'h0 || op[15:12] == 4'h8 ||
			op[15:12] == 4'hE || op[15:12] == 4'hF)
		else $error("bad opcode flagged on decoded group");

endmodule

bind chip8_instruction_core c8_chk u_c8_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_ch.valid),
	.rsp_ready(rsp_ch.ready),
	.pc       (rsp_ch.program_counter),
	.op       (rsp_ch.fetched_opcode),
	.wait_key (rsp_ch.waiting_for_key),
	.scr      (rsp_ch.screen_changed),
	.bad      (rsp_ch.bad_opcode)
);
